// ----- rtl/smf_pkg.sv -----
`default_nettype none

package smf_pkg;

    localparam int PIX_W      = 16;
    localparam int ROW_W      = 16;
    localparam int COL_W      = 12;
    localparam int FW_W       = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int WIDTH_RESET  = 1920;
    localparam int HEIGHT_RESET = 1080;
    localparam int WIDTH_LIMIT  = 4096;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

    // bit positions in the result mask, also the emission order
    localparam int RES_A   = 0;   // interior result, column - 1
    localparam int RES_B   = 1;   // interior result, last column
    localparam int RES_P   = 2;   // pass-through of the arriving pixel
    localparam int RES_NUM = 3;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    typedef struct packed {
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic [PIX_W-1:0]   val_a;
        logic [PIX_W-1:0]   val_b;
        logic [PIX_W-1:0]   pixel;
        logic [RES_NUM-1:0] emit;
    } job_t;

    // duplicate of any equal pair, else the minimum
    function automatic logic [PIX_W-1:0] vote3(input logic [PIX_W-1:0] a,
                                               input logic [PIX_W-1:0] b,
                                               input logic [PIX_W-1:0] c);
        logic [PIX_W-1:0] m;
        m = (a < b) ? a : b;
        if (a == b || a == c)
            vote3 = a;
        else if (b == c)
            vote3 = b;
        else
            vote3 = (m < c) ? m : c;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/smf_front.sv -----
`default_nettype none

module smf_front #(
    parameter int MAX_WIDTH = 4096
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    input  wire logic [smf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [smf_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [smf_pkg::PIX_W-1:0]      pixel,
    output logic                                push,
    output smf_pkg::job_t                       push_job,
    input  wire logic                           q_full
);

    localparam int AW          = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WIDTH_CLAMP = (MAX_WIDTH > smf_pkg::WIDTH_LIMIT) ?
                                 smf_pkg::WIDTH_LIMIT : MAX_WIDTH;
    localparam int WIDTH_RST   = (smf_pkg::WIDTH_RESET > WIDTH_CLAMP) ?
                                 WIDTH_CLAMP : smf_pkg::WIDTH_RESET;
    localparam int MW          = 2 * smf_pkg::PIX_W;
    localparam int FW_W_T      = smf_pkg::FW_W;

    // frame geometry, kept as last index
    logic [smf_pkg::COL_W-1:0] last_col_reg, last_col_next;
    logic [smf_pkg::ROW_W-1:0] last_row_reg, last_row_next;
    logic [smf_pkg::ROW_W-1:0] row_reg, row_next;
    logic [smf_pkg::COL_W-1:0] col_reg, col_next;

    logic [smf_pkg::PIX_W-1:0] recent0_reg, recent1_reg;
    logic [smf_pkg::PIX_W-1:0] edge0_reg, edge1_reg;   // last column, per row parity

    logic [MW-1:0]             mem [MAX_WIDTH];
    logic [MW-1:0]             mem_rd_reg;
    logic [MW-1:0]             wr_word;
    logic [AW-1:0]             rd_addr;
    logic                      wr_en;

    logic                      s1_valid_reg, s1_valid_next;
    logic [smf_pkg::ROW_W-1:0] s1_row_reg;
    logic [smf_pkg::COL_W-1:0] s1_col_reg;
    logic [smf_pkg::PIX_W-1:0] s1_pixel_reg, s1_hp_reg, s1_vote_b_reg;
    logic [AW-1:0]             s1_addr_reg;
    logic                      s1_slot_reg, s1_has_a_reg, s1_has_b_reg;
    logic                      s1_has_p_reg, s1_inter_reg;

    logic                      accept, s1_adv;
    logic                      has_a, has_b, has_p, interior;
    logic [smf_pkg::PIX_W-1:0] hp, vote_b, edge_cur, edge_mid, val_a;
    logic [smf_pkg::PIX_W-1:0] mem_lo, mem_hi;
    logic [smf_pkg::RES_NUM-1:0] emit;
    logic [FW_W_T-1:0]         fw;
    logic [smf_pkg::ROW_W-1:0] fh;

    // stage 0: classify the arriving pixel
    always_comb
    begin
        has_a    = (col_reg != '0);
        has_b    = (col_reg == last_col_reg);
        has_p    = (row_reg == '0) || (row_reg == last_row_reg);
        interior = (row_reg >= smf_pkg::ROW_W'(2));
        edge_cur = row_reg[0] ? edge1_reg : edge0_reg;
        edge_mid = row_reg[0] ? edge0_reg : edge1_reg;
        hp       = (col_reg == smf_pkg::COL_W'(1)) ? recent0_reg :
                   smf_pkg::vote3(recent1_reg, recent0_reg, pixel);
        vote_b   = smf_pkg::vote3(edge_cur, edge_mid, pixel);
        rd_addr  = AW'(col_reg - smf_pkg::COL_W'(1));
    end

    // stage 1: vertical vote against the two stored rows
    always_comb
    begin
        mem_lo          = mem_rd_reg[smf_pkg::PIX_W-1:0];
        mem_hi          = mem_rd_reg[MW-1:smf_pkg::PIX_W];
        val_a           = smf_pkg::vote3(mem_lo, mem_hi, s1_hp_reg);
        wr_word         = s1_slot_reg ? {s1_hp_reg, mem_lo} : {mem_hi, s1_hp_reg};
        emit            = '0;
        emit[smf_pkg::RES_A] = s1_has_a_reg && s1_inter_reg;
        emit[smf_pkg::RES_B] = s1_has_b_reg && s1_inter_reg;
        emit[smf_pkg::RES_P] = s1_has_p_reg;
        s1_adv          = s1_valid_reg && (!q_full || (emit == '0));
        push            = s1_valid_reg && (emit != '0) && !q_full;
        wr_en           = s1_adv && s1_has_a_reg;
        in_stall        = s1_valid_reg && !s1_adv;
        accept          = in_valid && !in_stall;
        push_job.row    = s1_row_reg;
        push_job.col    = s1_col_reg;
        push_job.val_a  = val_a;
        push_job.val_b  = s1_vote_b_reg;
        push_job.pixel  = s1_pixel_reg;
        push_job.emit   = emit;
    end

    always_comb
    begin
        s1_valid_next = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
        last_col_next = last_col_reg;
        last_row_next = last_row_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        fw            = cfg_data[FW_W_T-1:0];
        fh            = cfg_data[smf_pkg::ROW_W-1:0];
        if (fw == '0)
            fw = FW_W_T'(1);
        if (fw > FW_W_T'(WIDTH_CLAMP))
            fw = FW_W_T'(WIDTH_CLAMP);
        if (fh == '0)
            fh = smf_pkg::ROW_W'(1);
        if (accept)
        begin
            if (has_b)
            begin
                col_next = '0;
                row_next = (row_reg == last_row_reg) ? '0 : row_reg + smf_pkg::ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + smf_pkg::COL_W'(1);
            end
        end
        if (cfg_valid)
        begin
            case (cfg_index)
                smf_pkg::CFG_FRAME_WIDTH:
                begin
                    last_col_next = smf_pkg::COL_W'(fw - FW_W_T'(1));
                    row_next      = '0;
                    col_next      = '0;
                end
                smf_pkg::CFG_FRAME_HEIGHT:
                begin
                    last_row_next = fh - smf_pkg::ROW_W'(1);
                    row_next      = '0;
                    col_next      = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_col_reg <= smf_pkg::COL_W'(WIDTH_RST - 1);
            last_row_reg <= smf_pkg::ROW_W'(smf_pkg::HEIGHT_RESET - 1);
            row_reg      <= '0;
            col_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            last_col_reg <= last_col_next;
            last_row_reg <= last_row_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            recent1_reg   <= recent0_reg;
            recent0_reg   <= pixel;
            s1_row_reg    <= row_reg;
            s1_col_reg    <= col_reg;
            s1_pixel_reg  <= pixel;
            s1_hp_reg     <= hp;
            s1_vote_b_reg <= vote_b;
            s1_addr_reg   <= rd_addr;
            s1_slot_reg   <= row_reg[0];
            s1_has_a_reg  <= has_a;
            s1_has_b_reg  <= has_b;
            s1_has_p_reg  <= has_p;
            s1_inter_reg  <= interior;
            if (has_b)
            begin
                if (row_reg[0])
                    edge1_reg <= pixel;
                else
                    edge0_reg <= pixel;
            end
        end
    end

    // horizontal line store: {odd row, even row} per column
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[s1_addr_reg] <= wr_word;
        if (accept)
            mem_rd_reg <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ----- rtl/smf_queue.sv -----
`default_nettype none

module smf_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire smf_pkg::job_t push_job,
    output logic               full,
    input  wire logic          pop,
    output logic               empty,
    output smf_pkg::job_t      head
);

    smf_pkg::job_t                 data_reg [smf_pkg::Q_DEPTH];
    logic [smf_pkg::Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [smf_pkg::Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [smf_pkg::Q_CNT_W-1:0]   count_reg, count_next;
    logic                          do_push, do_pop;

    always_comb
    begin
        full        = (count_reg == smf_pkg::Q_CNT_W'(smf_pkg::Q_DEPTH));
        empty       = (count_reg == '0);
        do_push     = push && !full;
        do_pop      = pop && !empty;
        head        = data_reg[rd_ptr_reg];
        wr_ptr_next = do_push ? wr_ptr_reg + smf_pkg::Q_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + smf_pkg::Q_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + smf_pkg::Q_CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - smf_pkg::Q_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            data_reg[wr_ptr_reg] <= push_job;
    end

endmodule

`default_nettype wire

// ----- rtl/smf_back.sv -----
`default_nettype none

module smf_back (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      q_empty,
    input  wire smf_pkg::job_t             head,
    output logic                           pop,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic [smf_pkg::ROW_W-1:0]      out_row,
    output logic [smf_pkg::COL_W-1:0]      out_col,
    output logic [smf_pkg::PIX_W-1:0]      value,
    output logic                           last_of_run
);

    logic [smf_pkg::RES_NUM-1:0] done_reg, done_next;
    logic                        out_valid_reg, out_valid_next;
    logic [smf_pkg::ROW_W-1:0]   row_reg, row_sel;
    logic [smf_pkg::COL_W-1:0]   col_reg, col_sel;
    logic [smf_pkg::PIX_W-1:0]   value_reg, value_sel;
    logic                        last_reg, is_last;
    logic [smf_pkg::RES_NUM-1:0] rem, pick;
    logic                        load;

    always_comb
    begin
        rem     = head.emit & ~done_reg;
        pick    = rem & (~rem + smf_pkg::RES_NUM'(1));   // lowest pending result
        is_last = ((rem & ~pick) == '0);
        load    = !q_empty && (!out_valid_reg || !out_stall);
        pop     = load && is_last;
        if (pick[smf_pkg::RES_A])
        begin
            row_sel   = head.row - smf_pkg::ROW_W'(1);
            col_sel   = head.col - smf_pkg::COL_W'(1);
            value_sel = head.val_a;
        end
        else if (pick[smf_pkg::RES_B])
        begin
            row_sel   = head.row - smf_pkg::ROW_W'(1);
            col_sel   = head.col;
            value_sel = head.val_b;
        end
        else
        begin
            row_sel   = head.row;
            col_sel   = head.col;
            value_sel = head.pixel;
        end
        done_next = done_reg;
        if (load)
            done_next = is_last ? '0 : (done_reg | pick);
        out_valid_next = load ? 1'b1 : (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            row_reg   <= row_sel;
            col_reg   <= col_sel;
            value_reg <= value_sel;
            last_reg  <= is_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_row     = row_reg;
    assign out_col     = col_reg;
    assign value       = value_reg;
    assign last_of_run = last_reg;

endmodule

`default_nettype wire

// ----- rtl/separable_mode_filter_3x3.sv -----
// 3x3 separable mode filter for a 16-bit raster pixel stream.
// Input: pixel with in_valid/in_stall; a transfer happens on a clock where
// in_valid is high and in_stall is low. Output: out_row, out_col, value and
// last_of_run with out_valid/out_stall; last_of_run marks the final result
// caused by one input pixel (an input may cause zero to three results).
// Config: cfg_valid/cfg_ready with cfg_index (0 frame_width, 1 frame_height)
// and cfg_data; cfg_ready is always high. A write to either restarts at row 0.
// Write config only with the pipeline empty.
// Throughput: one pixel per clock on average while out_stall is low, as a frame
// gives one result per pixel and the output moves one result per clock. Row 1
// gives none; on the last row each pixel after the first gives two and the final
// pixel three, so there in_stall rises once the four-entry job queue is full.
// Path: a transferred pixel is classified and registered in stage 1 with the
// line-store read; its results then pass the job queue and output register.
// The line store is a single-port-write, single-read RAM of MAX_WIDTH words
// holding both prior horizontal rows; at most one read-modify-write per pixel.
// Reset: geometry returns to 1920x1080 (width capped at MAX_WIDTH), position to
// row 0 column 0, the job queue empty; the line store is not cleared.
// out_stall holds the output register; the queue then fills and in_stall
// rises, which freezes the front end with its payload intact.
`default_nettype none

module separable_mode_filter_3x3 #(
    parameter int MAX_WIDTH = 4096
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [smf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [smf_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [smf_pkg::PIX_W-1:0]      pixel,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [smf_pkg::ROW_W-1:0]           out_row,
    output logic [smf_pkg::COL_W-1:0]           out_col,
    output logic [smf_pkg::PIX_W-1:0]           value,
    output logic                                last_of_run
);

    smf_pkg::job_t push_job;
    smf_pkg::job_t head;
    logic          push, q_full, q_empty, pop;

    assign cfg_ready = 1'b1;

    // front: position tracking, horizontal vote, line-store vertical vote
    smf_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .pixel     (pixel),
        .push      (push),
        .push_job  (push_job),
        .q_full    (q_full)
    );

    // jobs carry up to three results each
    smf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .empty    (q_empty),
        .head     (head)
    );

    // back: serializes each job's results into the output register
    smf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .head        (head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_row     (out_row),
        .out_col     (out_col),
        .value       (value),
        .last_of_run (last_of_run)
    );

endmodule

`default_nettype wire

// ----- sim/tb_separable_mode_filter_3x3.sv -----
`default_nettype none

module tb_separable_mode_filter_3x3;

    timeunit 1ns;
    timeprecision 1ps;

    // index that no register answers to; a write there must leave the frame alone
    localparam logic [smf_pkg::CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

    localparam int RANDOM_ITEMS = 300;
    localparam int SETTLE       = 8;
    localparam int LONG_HOLD    = 120;   // receiver hold-off, in cycles
    localparam int IDLE_LIMIT   = 2000;  // cycles without any transfer
    localparam int WIDE_ROW     = 4096;

    // one filtered pixel as it leaves the block
    typedef struct {
        logic [smf_pkg::ROW_W-1:0] row;
        logic [smf_pkg::COL_W-1:0] col;
        logic [smf_pkg::PIX_W-1:0] val;
        logic                      last;
    } filt_pix_t;

    // Tracks the frame position, the two stored horizontal rows and the
    // queue of filtered pixels still owed by the block.
    class mode_filter_board;
        logic [smf_pkg::FW_W-1:0]  width_reg;
        logic [smf_pkg::ROW_W-1:0] height_reg;
        logic [smf_pkg::PIX_W-1:0] hrow_store [2*smf_pkg::WIDTH_LIMIT];
        logic [smf_pkg::PIX_W-1:0] prev_near;
        logic [smf_pkg::PIX_W-1:0] prev_far;
        int unsigned               row_pos;
        int unsigned               col_pos;
        filt_pix_t                 owed [$];
        filt_pix_t                 staged [smf_pkg::RES_NUM];
        int                        n_staged;
        int                        errors;
        int                        matched;

        function new();
            width_reg  = smf_pkg::WIDTH_RESET;
            height_reg = smf_pkg::HEIGHT_RESET;
            prev_near  = '0;
            prev_far   = '0;
            row_pos    = 0;
            col_pos    = 0;
            n_staged   = 0;
            errors     = 0;
            matched    = 0;
            foreach (hrow_store[i])
                hrow_store[i] = '0;
        endfunction

        function int unsigned frame_w();
            int unsigned w;
            w = width_reg;
            if (w == 0)
                w = 1;
            if (w > smf_pkg::WIDTH_LIMIT)
                w = smf_pkg::WIDTH_LIMIT;
            return w;
        endfunction

        function int unsigned frame_h();
            return (height_reg == 0) ? 1 : height_reg;
        endfunction

        static function logic [smf_pkg::PIX_W-1:0] pick3(
            input logic [smf_pkg::PIX_W-1:0] a,
            input logic [smf_pkg::PIX_W-1:0] b,
            input logic [smf_pkg::PIX_W-1:0] c);
            if (a == b || a == c)
                return a;
            if (b == c)
                return b;
            if (a < b && a < c)
                return a;
            return (b < c) ? b : c;
        endfunction

        function void stage(int unsigned r, int unsigned c, logic [smf_pkg::PIX_W-1:0] v);
            staged[n_staged].row  = r[smf_pkg::ROW_W-1:0];
            staged[n_staged].col  = c[smf_pkg::COL_W-1:0];
            staged[n_staged].val  = v;
            staged[n_staged].last = 1'b0;
            n_staged++;
        endfunction

        // vote down column j for row r-1, then keep h as row r's entry
        function void column_vote(int unsigned r, int unsigned j,
                                  logic [smf_pkg::PIX_W-1:0] h, bit interior);
            int unsigned               cur;
            int unsigned               mid;
            logic [smf_pkg::PIX_W-1:0] v;
            cur = (r % 2) * smf_pkg::WIDTH_LIMIT + j;
            mid = ((r + 1) % 2) * smf_pkg::WIDTH_LIMIT + j;
            v = pick3(hrow_store[cur], hrow_store[mid], h);
            hrow_store[cur] = h;
            if (interior)
                stage(r - 1, j, v);
        endfunction

        function void set_reg(logic [smf_pkg::CFG_IDX_W-1:0] idx,
                              logic [smf_pkg::CFG_DATA_W-1:0] data);
            if (idx == smf_pkg::CFG_FRAME_WIDTH)
                width_reg = data[smf_pkg::FW_W-1:0];
            else if (idx == smf_pkg::CFG_FRAME_HEIGHT)
                height_reg = data;
            else
                return;
            row_pos = 0;
            col_pos = 0;
        endfunction

        function void take_pixel(logic [smf_pkg::PIX_W-1:0] p);
            int unsigned               w;
            int unsigned               h;
            int unsigned               r;
            int unsigned               c;
            int                        i;
            bit                        interior;
            logic [smf_pkg::PIX_W-1:0] hp;
            w = frame_w();
            h = frame_h();
            r = row_pos;
            c = col_pos;
            n_staged = 0;
            interior = (r >= 2) && (r <= h - 1);
            if (r >= h || c >= w)
            begin
                r = 0;
                c = 0;
                interior = 0;
            end
            if (c >= 1)
            begin
                hp = (c == 1) ? prev_near : pick3(prev_far, prev_near, p);
                column_vote(r, c - 1, hp, interior);
            end
            if (c == w - 1)
                column_vote(r, c, p, interior);
            if (r == 0 || r == h - 1)
                stage(r, c, p);
            for (i = 0; i < n_staged; i++)
            begin
                staged[i].last = (i == n_staged - 1);
                owed.push_back(staged[i]);
            end
            prev_far  = prev_near;
            prev_near = p;
            c++;
            if (c >= w)
            begin
                c = 0;
                r++;
                if (r >= h)
                    r = 0;
            end
            row_pos = r;
            col_pos = c;
        endfunction

        function void check_result(logic [smf_pkg::ROW_W-1:0] row,
                                   logic [smf_pkg::COL_W-1:0] col,
                                   logic [smf_pkg::PIX_W-1:0] val, logic last);
            filt_pix_t e;
            int        bad;
            if (owed.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result: expected none, actual row %0d col %0d",
                         $time, row, col);
                $display("%0t:   actual value %h last %0b", $time, val, last);
                return;
            end
            e = owed.pop_front();
            bad = errors;
            if (row !== e.row)
            begin
                errors++;
                $display("%0t: out_row mismatch: expected %0d actual %0d", $time, e.row, row);
            end
            if (col !== e.col)
            begin
                errors++;
                $display("%0t: out_col mismatch: expected %0d actual %0d", $time, e.col, col);
            end
            if (val !== e.val)
            begin
                errors++;
                $display("%0t: value mismatch at (%0d,%0d): expected %h actual %h",
                         $time, e.row, e.col, e.val, val);
            end
            if (last !== e.last)
            begin
                errors++;
                $display("%0t: last_of_run mismatch at (%0d,%0d): expected %0b actual %0b",
                         $time, e.row, e.col, e.last, last);
            end
            if (errors == bad)
                matched++;
        endfunction
    endclass

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [smf_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [smf_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                           in_valid;
    logic                           in_stall;
    logic [smf_pkg::PIX_W-1:0]      pixel;
    logic                           out_valid;
    logic                           out_stall;
    logic [smf_pkg::ROW_W-1:0]      out_row;
    logic [smf_pkg::COL_W-1:0]      out_col;
    logic [smf_pkg::PIX_W-1:0]      value;
    logic                           last_of_run;

    mode_filter_board board;

    int                        burst_left = 0;    // sender transfers left before a gap
    int                        hold_requests = 0; // main asks the receiver for long holds
    logic [smf_pkg::PIX_W-1:0] palette [3];       // per-phase values, equal pairs common
    int                        pixels_in = 0;
    int                        phases = 0;

    separable_mode_filter_3x3 dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pixel       (pixel),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_row     (out_row),
        .out_col     (out_col),
        .value       (value),
        .last_of_run (last_of_run)
    );

    always #2 clk = ~clk;

    // All sampling happens here at the rising edge, before the block's own
    // updates of that edge land. Config, pixel and result transfers of one
    // edge are independent: a pixel never produces a result at its own edge.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (cfg_valid && cfg_ready)
                board.set_reg(cfg_index, cfg_data);
            if (in_valid && !in_stall)
            begin
                board.take_pixel(pixel);
                pixels_in++;
            end
            if (out_valid && !out_stall)
                board.check_result(out_row, out_col, value, last_of_run);
        end
    end

    // Receiver: out_stall follows a pattern that changes every so often
    // (free running, light, heavy, periodic). On request it holds off for a
    // long stretch so the job queue fills and in_stall has to rise.
    initial
    begin : receiver
        int mode;
        int left;
        int holds_done;
        mode = 0;
        left = 0;
        holds_done = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_requests != holds_done)
            begin
                holds_done = hold_requests;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
            end
            else
            begin
                if (left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(20, 150);
                end
                left--;
                case (mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 3) == 0);
                    2:       out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= ((left % 5) < 2);
                endcase
            end
        end
    end

    // Watchdog: ends the run if no transfer of any kind happens for too long.
    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                idle = 0;
            else
                idle++;
        end
        $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // One pixel transfer. The sender works in bursts; between bursts it drops
    // valid for a random gap. Valid stays up across back-to-back transfers.
    task automatic send_pixel(input logic [smf_pkg::PIX_W-1:0] p);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 20);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        burst_left--;
        in_valid <= 1'b1;
        pixel    <= p;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
    endtask

    // Stop sending and wait for every owed result, then wait longer so that
    // pixels which owe nothing have left the pipeline too.
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (board.owed.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [smf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [smf_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_geometry(input logic [smf_pkg::CFG_DATA_W-1:0] w_data,
                                input logic [smf_pkg::CFG_DATA_W-1:0] h_data);
        wait_drained();
        write_reg(smf_pkg::CFG_FRAME_WIDTH, w_data);
        write_reg(smf_pkg::CFG_FRAME_HEIGHT, h_data);
        phases++;
    endtask

    function automatic logic [smf_pkg::PIX_W-1:0] pick_pixel();
        int r;
        r = $urandom_range(0, 9);
        return (r < 7) ? palette[r % 3] : smf_pkg::PIX_W'($urandom);
    endfunction

    initial
    begin : main
        logic [smf_pkg::PIX_W-1:0]      frame3x3 [9];
        logic [smf_pkg::CFG_DATA_W-1:0] wd;
        logic [smf_pkg::CFG_DATA_W-1:0] hd;
        int                             random_items;
        int                             count;
        int                             area;
        int                             sel;
        int                             i;

        board = new();
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= smf_pkg::CFG_FRAME_WIDTH;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        pixel     <= '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset geometry (1920 x 1080): row 0 passes straight through
        send_pixel(16'h0000);
        send_pixel(16'hFFFF);
        send_pixel(16'h8000);

        // 3x3 frame: left pair equal, all distinct, extremes
        frame3x3 = '{16'h0005, 16'h0005, 16'h0007,
                     16'h0001, 16'h0002, 16'h0003,
                     16'hFFFF, 16'h0000, 16'hFFFF};
        set_geometry(16'd3, 16'd3);
        foreach (frame3x3[k])
            send_pixel(frame3x3[k]);

        // zero width and height count as one: every pixel passes through
        set_geometry(16'd0, 16'd0);
        send_pixel(16'hAAAA);
        send_pixel(16'h5555);
        send_pixel(16'h0000);

        // 2x2 frame, no interior rows; a write to the spare index mid-frame
        // must not restart the frame
        set_geometry(16'd2, 16'd2);
        send_pixel(16'h1234);
        send_pixel(16'h1234);
        wait_drained();
        write_reg(CFG_SPARE_IDX, 16'hFFFF);
        send_pixel(16'hFFFF);
        send_pixel(16'h0001);

        // backpressure: receiver holds off while the sender keeps offering
        set_geometry(16'd5, 16'd6);
        foreach (palette[k])
            palette[k] = smf_pkg::PIX_W'($urandom);
        hold_requests++;
        burst_left = 1000;
        for (i = 0; i < 30; i++)
            send_pixel(pick_pixel());
        burst_left = 0;

        // width data with all bits set saturates to the width limit;
        // then the widest row with two rows, both passed through
        set_geometry(16'hFFFF, 16'd1);
        for (i = 0; i < 12; i++)
            send_pixel(smf_pkg::PIX_W'($urandom));
        set_geometry(16'(WIDE_ROW), 16'd2);
        for (i = 0; i < 20; i++)
            send_pixel(smf_pkg::PIX_W'($urandom));

        // random phases: mostly whole small frames, some cut short
        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            sel = $urandom_range(0, 9);
            case (sel)
                0:
                begin
                    wd = 16'd1;
                    hd = 16'($urandom_range(1, 12));
                end
                1:
                begin
                    wd = 16'($urandom_range(1, 8));
                    hd = 16'($urandom_range(1, 2));
                end
                2:
                begin
                    wd = 16'($urandom_range(2, 6));
                    hd = 16'hFFFF;
                end
                3:
                begin
                    // upper data bits beyond the width register are dropped
                    wd = {3'b111, 13'($urandom_range(1, 12))};
                    hd = 16'($urandom_range(3, 6));
                end
                4:
                begin
                    wd = 16'($urandom_range(2, 5));
                    hd = 16'd0;
                end
                default:
                begin
                    wd = 16'($urandom_range(2, 9));
                    hd = 16'($urandom_range(3, 7));
                end
            endcase
            if ($urandom_range(0, 5) == 0)
            begin
                wait_drained();
                write_reg(CFG_SPARE_IDX, smf_pkg::CFG_DATA_W'($urandom));
            end
            else
                set_geometry(wd, hd);
            foreach (palette[k])
                palette[k] = smf_pkg::PIX_W'($urandom);
            area = board.frame_w() * board.frame_h();
            if (area > 60 || $urandom_range(0, 3) == 0)
                count = $urandom_range(1, 40);
            else
                count = area * $urandom_range(1, 2) +
                        (($urandom_range(0, 2) == 0) ? $urandom_range(1, area) : 0);
            for (i = 0; i < count; i++)
                send_pixel(pick_pixel());
            random_items += count;
        end

        wait_drained();
        repeat (SETTLE) @(posedge clk);
        if (board.owed.size() > 0)
        begin
            board.errors++;
            $display("%0t: %0d results never arrived, first at (%0d,%0d) value %h",
                     $time, board.owed.size(), board.owed[0].row, board.owed[0].col,
                     board.owed[0].val);
        end

        $display("Run: %0d pixels over %0d geometries, %0d filtered results matched,",
                 pixels_in, phases, board.matched);
        $display("     incl. width saturation, tall and degenerate frames and a long output hold");
        if (board.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire

// ----- separable_mode_filter_3x3.f -----
rtl/smf_pkg.sv
rtl/smf_front.sv
rtl/smf_queue.sv
rtl/smf_back.sv
rtl/separable_mode_filter_3x3.sv
sim/tb_separable_mode_filter_3x3.sv
